[src/jac_pkg.sv]
// ----------------------------------------------------------------------------
// jac_pkg
// Shared types and constants for the joystick axis conditioner.
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int FRACTION_BITS_DEF = 14;
    localparam int AXIS_COUNT_DEF    = 4;
    localparam int IN_AXES           = 4;
    localparam int AXIS_W            = 16;
    localparam int BUTTON_W          = 16;
    localparam int CFG_W             = 15;
    localparam int CFG_IDX_W         = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 1'b1;

    localparam logic [CFG_W-1:0] DEADZONE_RESET  = 15'd0;
    localparam logic [CFG_W-1:0] SMOOTHING_RESET = 15'd16384;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_TGT,
        ST_MUL,
        ST_FIN
    } jac_state_t;

    typedef struct packed
    {
        logic load;
        logic div_step;
        logic tgt_step;
        logic mul_step;
        logic mul_bit;
        logic finish;
    } jac_ctrl_t;

endpackage

[src/jac_lane.sv]
// ----------------------------------------------------------------------------
// jac_lane
// One axis: deadzone rescale by a bit-serial restoring divider, then
// interpolation toward the target by a bit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
module jac_lane
    import jac_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  jac_ctrl_t                ctrl,
    input  logic [FRACTION_BITS:0]   dz,
    input  logic signed [AXIS_W-1:0] raw,
    output logic signed [AXIS_W-1:0] value
);

    localparam int F     = FRACTION_BITS;
    localparam int MAG_W = (F + 1 > AXIS_W) ? F + 1 : AXIS_W;
    localparam int V_W   = MAG_W + 2;
    localparam int P_W   = V_W + F + 1;
    localparam int S_W   = P_W - F;
    localparam int VV_W  = S_W + 1;

    localparam longint SNAP_L = ((longint'(75) << F) + 500) / 1000;

    localparam logic signed [V_W-1:0]  ONE_V   = V_W'(longint'(1) << F);
    localparam logic signed [VV_W-1:0] ONE_VV  = VV_W'(longint'(1) << F);
    localparam logic signed [VV_W-1:0] SNAP_VV = VV_W'(SNAP_L);
    localparam logic [P_W-1:0]         HALF_P  = P_W'(longint'(1) << (F - 1));

    logic signed [AXIS_W-1:0] value_reg, value_next;
    logic                     zero_reg, zero_next;
    logic                     sat_reg, sat_next;
    logic                     neg_reg, neg_next;
    logic [F:0]               rem_reg, rem_next;
    logic [F:0]               div_reg, div_next;
    logic [F-1:0]             q_reg, q_next;
    logic                     tzero_reg, tzero_next;
    logic                     dneg_reg, dneg_next;
    logic [V_W-1:0]           dmag_reg, dmag_next;
    logic [P_W-1:0]           acc_reg, acc_next;

    logic signed [V_W-1:0]  raw_v, mag_v, dz_v, sub_v, dsub_v;
    logic [F+1:0]           r2, d_ext, r2_sub;
    logic                   ge;
    logic [F:0]             tmag;
    logic signed [V_W-1:0]  tmag_v, tgt_v, cur_v, diff_v;
    logic [P_W-1:0]         sum_p;
    logic [S_W-1:0]         step;
    logic signed [VV_W-1:0] step_vv, cur_vv, v, vm, v_clamp;

    always_comb
    begin
        raw_v  = {{(V_W-AXIS_W){raw[AXIS_W-1]}}, raw};
        mag_v  = raw_v[V_W-1] ? -raw_v : raw_v;
        dz_v   = {{(V_W-F-1){1'b0}}, dz};
        sub_v  = mag_v - dz_v;
        dsub_v = ONE_V - dz_v;

        r2     = {rem_reg, 1'b0};
        d_ext  = {1'b0, div_reg};
        ge     = (r2 >= d_ext);
        r2_sub = r2 - d_ext;

        if (zero_reg)
            tmag = '0;
        else if (sat_reg)
            tmag = {1'b1, {F{1'b0}}};
        else
            tmag = {1'b0, q_reg};
        tmag_v = {{(V_W-F-1){1'b0}}, tmag};
        tgt_v  = neg_reg ? -tmag_v : tmag_v;
        cur_v  = {{(V_W-AXIS_W){value_reg[AXIS_W-1]}}, value_reg};
        diff_v = tgt_v - cur_v;

        sum_p   = acc_reg + HALF_P;
        step    = sum_p[P_W-1:F];
        step_vv = {1'b0, step};
        cur_vv  = {{(VV_W-AXIS_W){value_reg[AXIS_W-1]}}, value_reg};
        v       = dneg_reg ? (cur_vv - step_vv) : (cur_vv + step_vv);
        vm      = v[VV_W-1] ? -v : v;
        if (tzero_reg && (vm < SNAP_VV))
            v_clamp = '0;
        else if (v > ONE_VV)
            v_clamp = ONE_VV;
        else if (v < -ONE_VV)
            v_clamp = -ONE_VV;
        else
            v_clamp = v;

        value_next = value_reg;
        zero_next  = zero_reg;
        sat_next   = sat_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        q_next     = q_reg;
        tzero_next = tzero_reg;
        dneg_next  = dneg_reg;
        dmag_next  = dmag_reg;
        acc_next   = acc_reg;

        if (ctrl.load)
        begin
            zero_next = (mag_v < dz_v) || (dz_v >= ONE_V);
            sat_next  = (mag_v >= ONE_V);
            neg_next  = raw_v[V_W-1];
            rem_next  = sub_v[F:0];
            div_next  = dsub_v[F:0];
            q_next    = '0;
        end

        if (ctrl.div_step)
        begin
            rem_next = ge ? r2_sub[F:0] : r2[F:0];
            q_next   = {q_reg[F-2:0], ge};
        end

        if (ctrl.tgt_step)
        begin
            tzero_next = (tmag == '0);
            dneg_next  = diff_v[V_W-1];
            dmag_next  = diff_v[V_W-1] ? -diff_v : diff_v;
            acc_next   = '0;
        end

        if (ctrl.mul_step)
            acc_next = {acc_reg[P_W-2:0], 1'b0}
                     + (ctrl.mul_bit ? {{(P_W-V_W){1'b0}}, dmag_reg} : '0);

        if (ctrl.finish)
            value_next = v_clamp[AXIS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else
            value_reg <= value_next;
    end

    always_ff @(posedge clk)
    begin
        zero_reg  <= zero_next;
        sat_reg   <= sat_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        q_reg     <= q_next;
        tzero_reg <= tzero_next;
        dneg_reg  <= dneg_next;
        dmag_reg  <= dmag_next;
        acc_reg   <= acc_next;
    end

    assign value = value_reg;

endmodule

[src/joystick_axis_conditioner_core.sv]
// ----------------------------------------------------------------------------
// joystick_axis_conditioner_core
// Sequence: an accepted input transaction is loaded, then come FRACTION_BITS
// divider steps, a target step, FRACTION_BITS+1 multiplier steps and a finish
// step, which waits while an earlier result is still pending, then out_valid.
// A new input transaction is taken only once the core is back in ST_IDLE after
// the finish step; divider and multiplier are serial, all axes run in parallel lanes.
// Reset: axis state cleared, deadzone 0, smoothing 1.0, both channels idle.
// ----------------------------------------------------------------------------
module joystick_axis_conditioner_core
    import jac_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int AXIS_COUNT    = AXIS_COUNT_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_write_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [BUTTON_W-1:0]        buttons,
    input  logic signed [AXIS_W-1:0]   left_x,
    input  logic signed [AXIS_W-1:0]   left_y,
    input  logic signed [AXIS_W-1:0]   right_x,
    input  logic signed [AXIS_W-1:0]   right_y,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [BUTTON_W-1:0]        buttons_out,
    output logic signed [AXIS_W-1:0]   smooth_left_x,
    output logic signed [AXIS_W-1:0]   smooth_left_y,
    output logic signed [AXIS_W-1:0]   smooth_right_x,
    output logic signed [AXIS_W-1:0]   smooth_right_y
);

    localparam int F     = FRACTION_BITS;
    localparam int CNT_W = $clog2(F + 1);
    localparam int EXT_W = (F + 1 > CFG_W) ? F + 1 : CFG_W;

    localparam logic [EXT_W-1:0] ONE_EXT  = EXT_W'(longint'(1) << F);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(F - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(F);

    jac_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [F:0]           s_sh_reg, s_sh_next;
    logic [CFG_W-1:0]     dz_cfg_reg, s_cfg_reg;
    logic [BUTTON_W-1:0]  buttons_hold_reg, buttons_hold_next;
    logic [BUTTON_W-1:0]  buttons_out_reg, buttons_out_next;
    logic                 out_valid_reg, out_valid_next;

    jac_ctrl_t            ctrl;
    logic [EXT_W-1:0]     dz_ext, s_ext, dz_sat, s_sat;
    logic [F:0]           dz_eff, s_eff;

    logic signed [AXIS_W-1:0] raw_arr [IN_AXES];
    logic signed [AXIS_W-1:0] val_arr [IN_AXES];

    always_comb
    begin
        dz_ext = {{(EXT_W-CFG_W){1'b0}}, dz_cfg_reg};
        s_ext  = {{(EXT_W-CFG_W){1'b0}}, s_cfg_reg};
        dz_sat = (dz_ext > ONE_EXT) ? ONE_EXT : dz_ext;
        s_sat  = (s_ext > ONE_EXT) ? ONE_EXT : s_ext;
        dz_eff = dz_sat[F:0];
        s_eff  = s_sat[F:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_cfg_reg <= DEADZONE_RESET;
            s_cfg_reg  <= SMOOTHING_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_DEADZONE:  dz_cfg_reg <= cfg_data;
                CFG_SMOOTHING: s_cfg_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        ctrl              = '0;
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        s_sh_next         = s_sh_reg;
        buttons_hold_next = buttons_hold_reg;
        buttons_out_next  = buttons_out_reg;
        in_ready          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load         = 1'b1;
                    buttons_hold_next = buttons;
                    cnt_next          = '0;
                    state_next        = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_TGT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_TGT:
            begin
                ctrl.tgt_step = 1'b1;
                s_sh_next     = s_eff;
                cnt_next      = '0;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                ctrl.mul_step = 1'b1;
                ctrl.mul_bit  = s_sh_reg[F];
                s_sh_next     = {s_sh_reg[F-1:0], 1'b0};
                if (cnt_reg == MUL_LAST)
                    state_next = ST_FIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.finish      = 1'b1;
                    buttons_out_next = buttons_hold_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (ctrl.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_sh_reg         <= s_sh_next;
        buttons_hold_reg <= buttons_hold_next;
        buttons_out_reg  <= buttons_out_next;
    end

    assign raw_arr[0] = left_x;
    assign raw_arr[1] = left_y;
    assign raw_arr[2] = right_x;
    assign raw_arr[3] = right_y;

    for (genvar g = 0; g < IN_AXES; g++)
    begin : g_axis
        if (g < AXIS_COUNT)
        begin : g_lane
            jac_lane #(
                .FRACTION_BITS (FRACTION_BITS)
            ) u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .dz    (dz_eff),
                .raw   (raw_arr[g]),
                .value (val_arr[g])
            );
        end
        else
        begin : g_none
            assign val_arr[g] = '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign buttons_out    = buttons_out_reg;
    assign smooth_left_x  = val_arr[0];
    assign smooth_left_y  = val_arr[1];
    assign smooth_right_x = val_arr[2];
    assign smooth_right_y = val_arr[3];

endmodule

[src/jac_checker.sv]
// ----------------------------------------------------------------------------
// jac_checker
// Port-level checks on the conditioner, bound to the top level.
// ----------------------------------------------------------------------------
module jac_checker
    import jac_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [BUTTON_W-1:0]      buttons_out,
    input logic signed [AXIS_W-1:0] smooth_left_x,
    input logic signed [AXIS_W-1:0] smooth_left_y,
    input logic signed [AXIS_W-1:0] smooth_right_x,
    input logic signed [AXIS_W-1:0] smooth_right_y
);

    localparam int ONE_I = 1 << FRACTION_BITS;

    // a pending result transaction keeps its buttons, left_x and right_y payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(buttons_out)
            && $stable(smooth_left_x) && $stable(smooth_right_y))
        else $error("result changed while stalled");

    // one report at a time: busy right after an input transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a new result only appears at the end of serial work
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without work in progress");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            smooth_left_x  <= ONE_I && smooth_left_x  >= -ONE_I &&
            smooth_left_y  <= ONE_I && smooth_left_y  >= -ONE_I &&
            smooth_right_x <= ONE_I && smooth_right_x >= -ONE_I &&
            smooth_right_y <= ONE_I && smooth_right_y >= -ONE_I)
        else $error("axis beyond full scale");

endmodule

bind joystick_axis_conditioner_core jac_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_jac_checker (.*);

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: joystick axis conditioner core
// Self-checking bench. A driver feeds controller reports from a queue, and an
// in-bench predictor works out the deadzone rescale and smoothing of each
// accepted report. A monitor compares every output transaction field by
// field. Covers directed corner reports, then stick gestures (holds and
// releases) under several deadzone and smoothing settings, random idling on
// both sides and a long back-pressure stretch.
// ----------------------------------------------------------------------------
module tb;
    import jac_pkg::*;

    localparam int     FB      = FRACTION_BITS_DEF;
    localparam longint ONE_Q   = longint'(1) << FB;
    localparam longint SNAP_Q  = ((longint'(75) << FB) + 500) / 1000;
    localparam int     LIMIT   = 500000;
    localparam int     PHASES  = 8;
    localparam int     PER_PHASE = 80;

    typedef struct packed
    {
        logic [BUTTON_W-1:0]             buttons;
        logic [IN_AXES-1:0][AXIS_W-1:0]  axes;
    } report_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = CFG_DEADZONE;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [BUTTON_W-1:0]        buttons = '0;
    logic signed [AXIS_W-1:0]   left_x = '0;
    logic signed [AXIS_W-1:0]   left_y = '0;
    logic signed [AXIS_W-1:0]   right_x = '0;
    logic signed [AXIS_W-1:0]   right_y = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [BUTTON_W-1:0]        buttons_out;
    logic signed [AXIS_W-1:0]   smooth_left_x;
    logic signed [AXIS_W-1:0]   smooth_left_y;
    logic signed [AXIS_W-1:0]   smooth_right_x;
    logic signed [AXIS_W-1:0]   smooth_right_y;

    // predictor state
    logic [CFG_W-1:0]           deadzone_cfg = DEADZONE_RESET;
    logic [CFG_W-1:0]           smooth_cfg = SMOOTHING_RESET;
    logic signed [AXIS_W-1:0]   axis_mem [IN_AXES] = '{default: '0};

    report_t                    pending_reports [$];
    report_t                    expected_reports [$];
    int                         mismatches = 0;
    int                         cycle_cnt = 0;
    logic                       calm = 1'b0;
    logic                       rx_hold_arm = 1'b0;
    logic                       rx_hold_used = 1'b0;
    int                         rx_hold_cnt = 0;

    joystick_axis_conditioner_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .buttons        (buttons),
        .left_x         (left_x),
        .left_y         (left_y),
        .right_x        (right_x),
        .right_y        (right_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .buttons_out    (buttons_out),
        .smooth_left_x  (smooth_left_x),
        .smooth_left_y  (smooth_left_y),
        .smooth_right_x (smooth_right_x),
        .smooth_right_y (smooth_right_y)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // one axis: deadzone rescale, interpolate toward target, snap, clamp
    function automatic logic signed [AXIS_W-1:0] step_axis(
        input logic signed [AXIS_W-1:0] cur_v,
        input logic signed [AXIS_W-1:0] raw_v,
        input longint                   dz,
        input longint                   s
    );
        longint raw;
        longint cur;
        longint mag;
        longint tgt;
        longint prod;
        longint pmag;
        longint stp;
        longint v;
        logic signed [AXIS_W-1:0] res;
        raw = raw_v;
        cur = cur_v;
        mag = (raw < 0) ? -raw : raw;
        if (mag < dz || dz >= ONE_Q)
            tgt = 0;
        else
        begin
            tgt = ((mag - dz) * ONE_Q) / (ONE_Q - dz);
            if (tgt > ONE_Q)
                tgt = ONE_Q;
            if (raw <= 0)
                tgt = -tgt;
        end
        prod = (tgt - cur) * s;
        pmag = (prod < 0) ? -prod : prod;
        stp  = (pmag + (ONE_Q >>> 1)) >>> FB;
        v    = cur + ((prod < 0) ? -stp : stp);
        if (tgt == 0 && ((v < 0) ? -v : v) < SNAP_Q)
            v = 0;
        if (v > ONE_Q)
            v = ONE_Q;
        if (v < -ONE_Q)
            v = -ONE_Q;
        res = v[AXIS_W-1:0];
        return res;
    endfunction

    function automatic report_t condition_report(input report_t raw_rep);
        report_t res;
        longint  dz;
        longint  s;
        dz = (deadzone_cfg > ONE_Q) ? ONE_Q : longint'(deadzone_cfg);
        s  = (smooth_cfg > ONE_Q) ? ONE_Q : longint'(smooth_cfg);
        res.buttons = raw_rep.buttons;
        for (int k = 0; k < IN_AXES; k++)
        begin
            res.axes[k] = step_axis(axis_mem[k], raw_rep.axes[k], dz, s);
            axis_mem[k] = res.axes[k];
        end
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_reports.push_back(condition_report(pending_reports[0]));
                void'(pending_reports.pop_front());
            end
            if (!in_valid || in_ready)
            begin
                if (pending_reports.size() != 0 && (calm || $urandom_range(0, 99) >= 14))
                begin
                    in_valid <= 1'b1;
                    buttons  <= pending_reports[0].buttons;
                    left_x   <= pending_reports[0].axes[0];
                    left_y   <= pending_reports[0].axes[1];
                    right_x  <= pending_reports[0].axes[2];
                    right_y  <= pending_reports[0].axes[3];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin : monitor
        report_t want;
        report_t got;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            rx_hold_cnt  <= 0;
            rx_hold_used <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.buttons = buttons_out;
                got.axes[0] = smooth_left_x;
                got.axes[1] = smooth_left_y;
                got.axes[2] = smooth_right_x;
                got.axes[3] = smooth_right_y;
                if (expected_reports.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected transaction, buttons_out %h", $realtime,
                                 got.buttons);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.buttons !== want.buttons)
                    begin
                        if (mismatches < 10)
                            $display("%0t: buttons_out expected %h got %h", $realtime,
                                     want.buttons, got.buttons);
                        mismatches++;
                    end
                    for (int k = 0; k < IN_AXES; k++)
                    begin
                        if (got.axes[k] !== want.axes[k])
                        begin
                            if (mismatches < 10)
                                $display("%0t: axis %0d expected %0d got %0d", $realtime, k,
                                         $signed(want.axes[k]), $signed(got.axes[k]));
                            mismatches++;
                        end
                    end
                end
            end
            if (rx_hold_arm && !rx_hold_used)
            begin
                rx_hold_used <= 1'b1;
                rx_hold_cnt  <= 500;
                out_ready    <= 1'b0;
            end
            else if (rx_hold_cnt != 0)
            begin
                rx_hold_cnt <= rx_hold_cnt - 1;
                out_ready   <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        if (idx == CFG_DEADZONE)
            deadzone_cfg = val;
        else
            smooth_cfg = val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reports.size() != 0 || expected_reports.size() != 0);
    endtask

    task automatic queue_report(input int b, input int lx, input int ly, input int rx,
                                input int ry);
        report_t r;
        r.buttons = b[BUTTON_W-1:0];
        r.axes[0] = lx[AXIS_W-1:0];
        r.axes[1] = ly[AXIS_W-1:0];
        r.axes[2] = rx[AXIS_W-1:0];
        r.axes[3] = ry[AXIS_W-1:0];
        pending_reports.push_back(r);
    endtask

    function automatic logic signed [AXIS_W-1:0] rand_axis(input longint dz);
        logic signed [AXIS_W-1:0] v;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            v = AXIS_W'(int'($urandom_range(0, 32768)) - 16384);
        else if (pick < 65)
            v = AXIS_W'(int'($urandom_range(0, 4000)) - 2000);
        else if (pick < 80)
        begin
            v = AXIS_W'(dz + longint'($urandom_range(0, 2)) - 1);
            if ($urandom_range(0, 1))
                v = -v;
        end
        else if (pick < 90)
            v = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        else
            v = AXIS_W'($urandom);
        return v;
    endfunction

    // stick gestures: a position held with jitter for a few reports, some
    // releases to centre, some pure noise runs
    task automatic run_gestures(input int count);
        logic signed [AXIS_W-1:0] base [IN_AXES];
        logic signed [AXIS_W-1:0] jit;
        logic [BUTTON_W-1:0]      btn;
        report_t                  r;
        int                       left;
        int                       run;
        int                       j;
        bit                       noise;
        left = count;
        while (left > 0)
        begin
            run   = $urandom_range(1, 8);
            noise = ($urandom_range(0, 99) < 15);
            btn   = BUTTON_W'($urandom);
            for (int k = 0; k < IN_AXES; k++)
                base[k] = ($urandom_range(0, 3) == 0) ? '0 :
                          rand_axis(longint'(deadzone_cfg));
            for (j = 0; j < run && left > 0; j++)
            begin
                if ($urandom_range(0, 3) == 0)
                    btn = BUTTON_W'($urandom);
                r.buttons = btn;
                for (int k = 0; k < IN_AXES; k++)
                begin
                    jit = $urandom_range(0, 1) ? '0 : AXIS_W'($urandom_range(0, 64)) - 16'sd32;
                    r.axes[k] = noise ? rand_axis(longint'(deadzone_cfg)) : base[k] + jit;
                end
                pending_reports.push_back(r);
                left--;
            end
        end
    endtask

    initial
    begin
        int unsigned dz_plan [PHASES];
        int unsigned sm_plan [PHASES];
        dz_plan = '{0, 2000, 16384, 32767, 6000, 500, 0, 0};
        sm_plan = '{16384, 8192, 3000, 32767, 1000, 0, 0, 0};
        dz_plan[6] = $urandom_range(0, 16384);
        sm_plan[6] = $urandom_range(1, 16384);
        dz_plan[7] = $urandom_range(0, 32767);
        sm_plan[7] = $urandom_range(0, 32767);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, field extremes
        queue_report(16'h0000, 0, 0, 0, 0);
        queue_report(16'hFFFF, 16384, -16384, 32767, -32768);
        queue_report(16'hAAAA, 1, -1, 16383, -16383);
        queue_report(16'h5555, 0, 0, 0, 0);
        wait_drained();

        // deadzone edges
        write_reg(CFG_DEADZONE, 15'd4096);
        queue_report(16'h0001, 4095, -4095, 4096, -4097);
        queue_report(16'h8000, 16384, -16384, 4097, 8000);
        wait_drained();

        // smoothing ramp, then release to centre and snap
        write_reg(CFG_SMOOTHING, 15'd4096);
        repeat (3) queue_report(16'h00FF, 16384, -16384, 10000, -10000);
        repeat (4) queue_report(16'hFF00, 0, 0, 0, 0);
        wait_drained();

        // full-scale deadzone, then both registers above one
        write_reg(CFG_DEADZONE, 15'd16384);
        queue_report(16'h1234, 16384, -16384, 32767, -32768);
        wait_drained();
        write_reg(CFG_DEADZONE, 15'd32767);
        write_reg(CFG_SMOOTHING, 15'd32767);
        queue_report(16'h4321, 16384, -16384, 32767, -32768);
        queue_report(16'h0F0F, 0, 0, 0, 0);
        wait_drained();

        // zero smoothing holds state
        write_reg(CFG_DEADZONE, 15'd0);
        queue_report(16'hF0F0, 16384, -16384, 12000, -12000);
        wait_drained();
        write_reg(CFG_SMOOTHING, 15'd0);
        queue_report(16'hC3C3, -16384, 16384, 0, 5);
        queue_report(16'h3C3C, 0, 0, 0, 0);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_DEADZONE, CFG_W'(dz_plan[p]));
            write_reg(CFG_SMOOTHING, CFG_W'(sm_plan[p]));
            calm <= (p == 1);
            if (p == 4)
                rx_hold_arm <= 1'b1;
            run_gestures(PER_PHASE);
            wait_drained();
            calm <= 1'b0;
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
